// ===== src/lazy_delete_max_heap_with_links_core_assert.svh =====
// Assertion macros used by the lazy-deletion heap controller.
`ifndef LAZY_DELETE_MAX_HEAP_WITH_LINKS_CORE_ASSERT_SVH
`define LAZY_DELETE_MAX_HEAP_WITH_LINKS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ldmh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LDMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ldmh: next-cycle check failed");

`endif

// ===== src/ldmh_pkg.sv =====
// Shared types, codes and controller/datapath interface of the lazy-deletion heap.
package ldmh_pkg;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_LEFT  = 3'd2;
  localparam logic [2:0] OP_RIGHT = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_DUP   = 3'd1;
  localparam logic [2:0] STS_EMPTY = 3'd2;
  localparam logic [2:0] STS_FULL  = 3'd3;
  localparam logic [2:0] STS_NF    = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic [15:0]        first_token;
    logic [9:0]         first_pos;
    logic [15:0]        second_token;
    logic [9:0]         second_pos;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [15:0]        out_first_token;
    logic [9:0]         out_first_pos;
    logic [15:0]        out_second_token;
    logic [9:0]         out_second_pos;
  } out_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_PUSH, S_UP, S_UP2, S_POP, S_POP2, S_DN, S_DN2,
    S_CHK, S_CHK2, S_LEFT, S_LEFT2, S_RIGHT, S_CLR
  } state_t;

  typedef enum logic [4:0] {
    ST_NONE, ST_LATCH, ST_PUSH_RD, ST_PUSH_WR, ST_UP_RD, ST_UP_MOVE, ST_UP_END,
    ST_POP_RD, ST_POP_TAKE, ST_DN_RD, ST_DN_MOVE, ST_DN_END, ST_CHK_RD,
    ST_CHK_KILL, ST_LEFT_RD, ST_LEFT_RD2, ST_RIGHT_RD, ST_CLR_STEP
  } step_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_OK0, RES_DUP, RES_EMPTY, RES_FULL, RES_NF, RES_TOP, RES_ELEM
  } res_t;

  typedef struct packed {
    step_t step;
    res_t  res;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       push_bad;
    logic       fp_bad;
    logic       sp_bad;
    logic       cnt_zero;
    logic       slot_busy;
    logic       up_root;
    logic       up_swap;
    logic       dn_leaf;
    logic       dn_swap;
    logic       live;
    logic       left_hit;
    logic       elem_valid;
    logic       right_hit;
    logic       clr_last;
  } dp_stat_t;

endpackage

// ===== src/ldmh_ctrl.sv =====
// Sequencing state machine of the lazy-deletion heap.
`include "lazy_delete_max_heap_with_links_core_assert.svh"

module ldmh_ctrl
  import ldmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.step  = ST_NONE;
    cmd.res   = RES_NONE;
    case (state_r)
      S_INIT: begin
        cmd.step = ST_CLR_STEP;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.step  = ST_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              cmd.res   = RES_FULL;
              state_nxt = S_IDLE;
            end else if (stat.push_bad) begin
              cmd.res   = RES_DUP;
              state_nxt = S_IDLE;
            end else begin
              cmd.step  = ST_PUSH_RD;
              state_nxt = S_PUSH;
            end
          end
          OP_POP: state_nxt = S_POP;
          OP_LEFT: begin
            if (stat.fp_bad) begin
              cmd.res   = RES_NF;
              state_nxt = S_IDLE;
            end else begin
              cmd.step  = ST_LEFT_RD;
              state_nxt = S_LEFT;
            end
          end
          OP_RIGHT: begin
            if (stat.sp_bad) begin
              cmd.res   = RES_NF;
              state_nxt = S_IDLE;
            end else begin
              cmd.step  = ST_RIGHT_RD;
              state_nxt = S_RIGHT;
            end
          end
          OP_CLEAR: state_nxt = S_CLR;
          default: begin
            cmd.res   = RES_OK0;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PUSH: begin
        if (stat.slot_busy) begin
          cmd.res   = RES_DUP;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = ST_PUSH_WR;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (stat.up_root) begin
          cmd.step  = ST_UP_END;
          cmd.res   = RES_OK0;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = ST_UP_RD;
          state_nxt = S_UP2;
        end
      end
      S_UP2: begin
        if (stat.up_swap) begin
          cmd.step  = ST_UP_MOVE;
          state_nxt = S_UP;
        end else begin
          cmd.step  = ST_UP_END;
          cmd.res   = RES_OK0;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.cnt_zero) begin
          cmd.res   = RES_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = ST_POP_RD;
          state_nxt = S_POP2;
        end
      end
      S_POP2: begin
        cmd.step  = ST_POP_TAKE;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (stat.dn_leaf) begin
          cmd.step  = ST_DN_END;
          state_nxt = S_CHK;
        end else begin
          cmd.step  = ST_DN_RD;
          state_nxt = S_DN2;
        end
      end
      S_DN2: begin
        if (stat.dn_swap) begin
          cmd.step  = ST_DN_MOVE;
          state_nxt = S_DN;
        end else begin
          cmd.step  = ST_DN_END;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.step  = ST_CHK_RD;
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        // A stale top is dropped and the next one is taken.
        if (stat.live) begin
          cmd.step  = ST_CHK_KILL;
          cmd.res   = RES_TOP;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_LEFT: begin
        if (stat.left_hit) begin
          cmd.step  = ST_LEFT_RD2;
          state_nxt = S_LEFT2;
        end else begin
          cmd.res   = RES_NF;
          state_nxt = S_IDLE;
        end
      end
      S_LEFT2: begin
        cmd.res   = stat.elem_valid ? RES_ELEM : RES_NF;
        state_nxt = S_IDLE;
      end
      S_RIGHT: begin
        cmd.res   = stat.right_hit ? RES_ELEM : RES_NF;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.step = ST_CLR_STEP;
        if (stat.clr_last) begin
          cmd.res   = RES_OK0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `LDMH_ASSERT_NEXT(a_accept_decodes, start && !busy, state_r == S_DEC)
  `LDMH_ASSERT_NOW(a_idle_no_result, state_r == S_IDLE, cmd.res == RES_NONE)
  `LDMH_ASSERT_NOW(a_dn2_after_dn, state_r == S_DN2, $past(state_r) == S_DN)

endmodule

// ===== src/ldmh_dp.sv =====
// Datapath of the lazy-deletion heap: heap memory, link tables and result register.
module ldmh_dp
  import ldmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024,
  parameter int POSITIONS  = 1024,
  parameter int TOKEN_BITS = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     out_strobe,
  output out_t     out_data
);

  localparam int HA = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int PA = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int TW = (TOKEN_BITS < 16) ? TOKEN_BITS : 16;
  localparam int KB = KEY_BITS;
  localparam int CW = HA + 1;
  localparam int LW = HA + 2;

  typedef struct packed {
    logic signed [KB-1:0] key;
    logic [TW-1:0]        ft;
    logic [PA-1:0]        fp;
    logic [TW-1:0]        st;
    logic [PA-1:0]        sp;
  } hent_t;

  typedef struct packed {
    logic                 valid;
    logic [TW-1:0]        tag;
    logic [TW-1:0]        tok;
    logic [PA-1:0]        pos;
    logic signed [KB-1:0] key;
  } fent_t;

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] tag;
    logic [PA-1:0] pos;
  } rent_t;

  hent_t heap_mem [HEAP_DEPTH];
  fent_t fwd_mem  [POSITIONS];
  rent_t rev_mem  [POSITIONS];

  hent_t         lat_r, lat_nxt, ent_r, ent_nxt, top_r, top_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          fpbad_r, fpbad_nxt, spbad_r, spbad_nxt;
  logic [HA-1:0] i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PA-1:0] clr_r, clr_nxt;
  logic [PA-1:0] fwd_ra_r;
  hent_t         hrd_a_r, hrd_b_r;
  fent_t         fwd_rd_r;
  rent_t         rev_rd_r;
  logic          out_strobe_r, out_strobe_nxt;
  out_t          out_r, out_nxt;

  logic [HA-1:0] h_ra_a, h_ra_b, h_wa;
  logic          h_we;
  hent_t         h_wd;
  logic [PA-1:0] f_ra, f_wa, r_ra, r_wa;
  logic          f_we, r_we;
  fent_t         f_wd;
  rent_t         r_wd;

  logic [HA-1:0] pidx, cidx;
  logic [LW-1:0] lw, l1, cl;
  logic [CW-1:0] cm1;
  logic          useb, clr_last;
  hent_t         child;
  logic [31:0]   fp32, sp32, ft32, st32;

  assign fp32 = 32'(in_data.first_pos);
  assign sp32 = 32'(in_data.second_pos);
  assign ft32 = 32'(in_data.first_token);
  assign st32 = 32'(in_data.second_token);

  assign pidx  = HA'((i_r - 1'b1) >> 1);
  assign lw    = LW'({i_r, 1'b1});
  assign l1    = lw + 1'b1;
  assign cl    = LW'(cnt_r);
  assign cm1   = cnt_r - 1'b1;
  assign useb  = (l1 < cl) && ($signed(hrd_b_r.key) > $signed(hrd_a_r.key));
  assign child = useb ? hrd_b_r : hrd_a_r;
  assign cidx  = useb ? l1[HA-1:0] : lw[HA-1:0];
  assign clr_last = (clr_r == PA'(POSITIONS - 1));

  always_comb begin
    stat.op         = op_r;
    stat.full       = (cnt_r == CW'(HEAP_DEPTH));
    stat.push_bad   = fpbad_r | spbad_r;
    stat.fp_bad     = fpbad_r;
    stat.sp_bad     = spbad_r;
    stat.cnt_zero   = (cnt_r == '0);
    stat.slot_busy  = fwd_rd_r.valid | rev_rd_r.valid;
    stat.up_root    = (i_r == '0);
    stat.up_swap    = $signed(hrd_a_r.key) < $signed(ent_r.key);
    stat.dn_leaf    = (lw >= cl);
    stat.dn_swap    = $signed(child.key) > $signed(ent_r.key);
    stat.live       = fwd_rd_r.valid && (fwd_rd_r.tag == top_r.ft) &&
                      (fwd_rd_r.tok == top_r.st) && (fwd_rd_r.pos == top_r.sp);
    stat.left_hit   = rev_rd_r.valid && (rev_rd_r.tag == lat_r.ft);
    stat.elem_valid = fwd_rd_r.valid;
    stat.right_hit  = fwd_rd_r.valid && (fwd_rd_r.tag == lat_r.st);
    stat.clr_last   = clr_last;
  end

  // Memory port addressing and writes per datapath step.
  always_comb begin
    h_ra_a = '0;
    h_ra_b = '0;
    h_we   = 1'b0;
    h_wa   = i_r;
    h_wd   = ent_r;
    f_ra   = '0;
    f_we   = 1'b0;
    f_wa   = '0;
    f_wd   = '0;
    r_ra   = '0;
    r_we   = 1'b0;
    r_wa   = '0;
    r_wd   = '0;
    case (cmd.step)
      ST_PUSH_RD: begin
        f_ra = lat_r.fp;
        r_ra = lat_r.sp;
      end
      ST_PUSH_WR: begin
        f_we = 1'b1;
        f_wa = lat_r.fp;
        f_wd = '{valid: 1'b1, tag: lat_r.ft, tok: lat_r.st, pos: lat_r.sp, key: lat_r.key};
        r_we = 1'b1;
        r_wa = lat_r.sp;
        r_wd = '{valid: 1'b1, tag: lat_r.st, pos: lat_r.fp};
      end
      ST_UP_RD:   h_ra_a = pidx;
      ST_UP_MOVE: begin
        h_we = 1'b1;
        h_wd = hrd_a_r;
      end
      ST_UP_END:  h_we = 1'b1;
      ST_POP_RD: begin
        h_ra_a = '0;
        h_ra_b = cm1[HA-1:0];
      end
      ST_DN_RD: begin
        h_ra_a = lw[HA-1:0];
        h_ra_b = l1[HA-1:0];
      end
      ST_DN_MOVE: begin
        h_we = 1'b1;
        h_wd = child;
      end
      ST_DN_END:  h_we = 1'b1;
      ST_CHK_RD:  f_ra = top_r.fp;
      ST_CHK_KILL: begin
        f_we = 1'b1;
        f_wa = top_r.fp;
        r_we = 1'b1;
        r_wa = top_r.sp;
      end
      ST_LEFT_RD:  r_ra = lat_r.fp;
      ST_LEFT_RD2: f_ra = rev_rd_r.pos;
      ST_RIGHT_RD: f_ra = lat_r.sp;
      ST_CLR_STEP: begin
        f_we = 1'b1;
        f_wa = clr_r;
        r_we = 1'b1;
        r_wa = clr_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    hrd_a_r <= heap_mem[h_ra_a];
    hrd_b_r <= heap_mem[h_ra_b];
  end

  always_ff @(posedge clk) begin
    if (f_we) fwd_mem[f_wa] <= f_wd;
    fwd_rd_r <= fwd_mem[f_ra];
    fwd_ra_r <= f_ra;
  end

  always_ff @(posedge clk) begin
    if (r_we) rev_mem[r_wa] <= r_wd;
    rev_rd_r <= rev_mem[r_ra];
  end

  always_comb begin
    lat_nxt   = lat_r;
    op_nxt    = op_r;
    fpbad_nxt = fpbad_r;
    spbad_nxt = spbad_r;
    ent_nxt   = ent_r;
    top_nxt   = top_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    case (cmd.step)
      ST_LATCH: begin
        op_nxt     = in_data.op;
        lat_nxt.key = in_data.key[KB-1:0];
        lat_nxt.ft = ft32[TW-1:0];
        lat_nxt.st = st32[TW-1:0];
        lat_nxt.fp = fp32[PA-1:0];
        lat_nxt.sp = sp32[PA-1:0];
        fpbad_nxt  = (fp32 >= 32'(POSITIONS));
        spbad_nxt  = (sp32 >= 32'(POSITIONS));
      end
      ST_PUSH_WR: begin
        i_nxt   = cnt_r[HA-1:0];
        cnt_nxt = cnt_r + 1'b1;
        ent_nxt = lat_r;
      end
      ST_UP_MOVE: i_nxt = pidx;
      ST_POP_TAKE: begin
        top_nxt = hrd_a_r;
        ent_nxt = hrd_b_r;
        cnt_nxt = cm1;
        i_nxt   = '0;
      end
      ST_DN_MOVE: i_nxt = cidx;
      ST_CLR_STEP: begin
        cnt_nxt = '0;
        clr_nxt = clr_last ? '0 : clr_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic [31:0] t_ft, t_st, t_fp, t_sp;
    t_ft = '0;
    t_st = '0;
    t_fp = '0;
    t_sp = '0;
    out_strobe_nxt = (cmd.res != RES_NONE);
    out_nxt        = '0;
    case (cmd.res)
      RES_DUP:   out_nxt.status = STS_DUP;
      RES_EMPTY: out_nxt.status = STS_EMPTY;
      RES_FULL:  out_nxt.status = STS_FULL;
      RES_NF:    out_nxt.status = STS_NF;
      RES_TOP: begin
        t_ft = 32'(top_r.ft);
        t_st = 32'(top_r.st);
        t_fp = 32'(top_r.fp);
        t_sp = 32'(top_r.sp);
        out_nxt.status           = STS_OK;
        out_nxt.out_key          = 32'(top_r.key);
        out_nxt.out_first_token  = t_ft[15:0];
        out_nxt.out_first_pos    = t_fp[9:0];
        out_nxt.out_second_token = t_st[15:0];
        out_nxt.out_second_pos   = t_sp[9:0];
      end
      RES_ELEM: begin
        t_ft = 32'(fwd_rd_r.tag);
        t_st = 32'(fwd_rd_r.tok);
        t_fp = 32'(fwd_ra_r);
        t_sp = 32'(fwd_rd_r.pos);
        out_nxt.status           = STS_OK;
        out_nxt.out_key          = 32'(fwd_rd_r.key);
        out_nxt.out_first_token  = t_ft[15:0];
        out_nxt.out_first_pos    = t_fp[9:0];
        out_nxt.out_second_token = t_st[15:0];
        out_nxt.out_second_pos   = t_sp[9:0];
      end
      default: out_nxt.status = STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_r   <= lat_nxt;
    op_r    <= op_nxt;
    fpbad_r <= fpbad_nxt;
    spbad_r <= spbad_nxt;
    ent_r   <= ent_nxt;
    top_r   <= top_nxt;
    i_r     <= i_nxt;
    out_r   <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ===== src/lazy_delete_max_heap_with_links_core.sv =====
// Top level of the lazy-deletion max heap with forward and reverse link tables.
//
//   channel | ports                     | transfer
//   input   | start, busy, in_data      | edge with start high and busy low
//   result  | out_strobe, out_data      | edge ending the one strobe cycle
//
// Push keeps busy high while the new entry is compared with its parent level by
// level; a full push is refused at decode and a duplicate at decode or after the
// link read. Pop sifts down level by level, and each stale top discarded repeats
// the pop; an empty pop ends at once. Left queries read the reverse table, then
// the forward table; right queries read the forward table only. After reset a
// clearing pass over all POSITIONS entries runs with busy high, as clear does.
// The result appears in the cycle after the last step, while busy is already low; the receiver cannot stall.
module lazy_delete_max_heap_with_links_core
  import ldmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024,
  parameter int POSITIONS  = 1024,
  parameter int TOKEN_BITS = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ldmh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ldmh_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .POSITIONS  (POSITIONS),
    .TOKEN_BITS (TOKEN_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== dv/heap_link_checker.sv =====
// Checker for the lazy-deletion heap: mirrors the queue and link tables and compares results.
module heap_link_checker
  import ldmh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_strobe,
  input  out_t out_data,
  output int   pending,
  output int   errors
);

  localparam int DEPTH = 1024;
  localparam int SLOTS = 1024;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        ft;
    logic [9:0]         fp;
    logic [15:0]        st;
    logic [9:0]         sp;
  } cand_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [15:0] tok;
    logic [9:0]  pos;
  } link_t;

  cand_t              heap_q [DEPTH];
  int                 heap_n;
  link_t              fwd [SLOTS];
  link_t              rev [SLOTS];
  logic               elem_valid [SLOTS];
  logic signed [31:0] elem_key [SLOTS];
  logic [15:0]        elem_ft [SLOTS];
  logic [15:0]        elem_st [SLOTS];
  logic [9:0]         elem_sp [SLOTS];
  out_t               expected_results [$];

  function automatic void drop_links();
    for (int i = 0; i < SLOTS; i++) begin
      fwd[i].valid = 1'b0;
      rev[i].valid = 1'b0;
      elem_valid[i] = 1'b0;
    end
    heap_n = 0;
  endfunction

  function automatic cand_t take_top();
    cand_t top, t;
    int i, l, c;
    top = heap_q[0];
    heap_n--;
    heap_q[0] = heap_q[heap_n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      if (l >= heap_n) break;
      c = l;
      // Ties go to the left child.
      if (l + 1 < heap_n && heap_q[l + 1].key > heap_q[l].key) c = l + 1;
      if (heap_q[c].key > heap_q[i].key) begin
        t = heap_q[c]; heap_q[c] = heap_q[i]; heap_q[i] = t;
        i = c;
      end else begin
        break;
      end
    end
    return top;
  endfunction

  function automatic out_t element_at(logic [9:0] pos);
    out_t r;
    r = '0;
    if (!elem_valid[pos]) begin
      r.status = STS_NF;
    end else begin
      r.status = STS_OK;
      r.out_key = elem_key[pos];
      r.out_first_token = elem_ft[pos];
      r.out_first_pos = pos;
      r.out_second_token = elem_st[pos];
      r.out_second_pos = elem_sp[pos];
    end
    return r;
  endfunction

  function automatic out_t apply_command(in_t c);
    out_t r;
    cand_t e, t;
    int i, p;
    r = '0;
    r.status = STS_OK;
    case (c.op)
      OP_PUSH: begin
        if (heap_n >= DEPTH) begin
          r.status = STS_FULL;
        end else if (fwd[c.first_pos].valid || rev[c.second_pos].valid) begin
          r.status = STS_DUP;
        end else begin
          fwd[c.first_pos] = '{1'b1, c.first_token, c.second_token, c.second_pos};
          rev[c.second_pos] = '{1'b1, c.second_token, c.first_token, c.first_pos};
          elem_valid[c.first_pos] = 1'b1;
          elem_key[c.first_pos] = c.key;
          elem_ft[c.first_pos] = c.first_token;
          elem_st[c.first_pos] = c.second_token;
          elem_sp[c.first_pos] = c.second_pos;
          i = heap_n;
          heap_n = heap_n + 1;
          heap_q[i] = '{c.key, c.first_token, c.first_pos, c.second_token, c.second_pos};
          while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_q[p].key < heap_q[i].key) begin
              t = heap_q[p]; heap_q[p] = heap_q[i]; heap_q[i] = t;
              i = p;
            end else begin
              break;
            end
          end
        end
      end
      OP_POP: begin
        r.status = STS_EMPTY;
        // Stale tops are dropped until one still matches its forward link.
        while (heap_n > 0) begin
          e = take_top();
          if (fwd[e.fp].valid && fwd[e.fp].tag == e.ft && fwd[e.fp].tok == e.st &&
              fwd[e.fp].pos == e.sp) begin
            fwd[e.fp].valid = 1'b0;
            rev[e.sp].valid = 1'b0;
            elem_valid[e.fp] = 1'b0;
            r = '{STS_OK, e.key, e.ft, e.fp, e.st, e.sp};
            break;
          end
        end
      end
      OP_LEFT: begin
        if (!rev[c.first_pos].valid || rev[c.first_pos].tag != c.first_token)
          r.status = STS_NF;
        else
          r = element_at(rev[c.first_pos].pos);
      end
      OP_RIGHT: begin
        if (!fwd[c.second_pos].valid || fwd[c.second_pos].tag != c.second_token)
          r.status = STS_NF;
        else
          r = element_at(c.second_pos);
      end
      OP_CLEAR: drop_links();
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_result(out_t exp_r, out_t got);
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.out_key !== exp_r.out_key) begin
      $error("out_key: expected %0d, got %0d", exp_r.out_key, got.out_key);
      errors++;
    end
    if (got.out_first_token !== exp_r.out_first_token) begin
      $error("out_first_token: expected %0h, got %0h", exp_r.out_first_token,
             got.out_first_token);
      errors++;
    end
    if (got.out_first_pos !== exp_r.out_first_pos) begin
      $error("out_first_pos: expected %0d, got %0d", exp_r.out_first_pos, got.out_first_pos);
      errors++;
    end
    if (got.out_second_token !== exp_r.out_second_token) begin
      $error("out_second_token: expected %0h, got %0h", exp_r.out_second_token,
             got.out_second_token);
      errors++;
    end
    if (got.out_second_pos !== exp_r.out_second_pos) begin
      $error("out_second_pos: expected %0d, got %0d", exp_r.out_second_pos,
             got.out_second_pos);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    drop_links();
  end

  // Results are matched before a command accepted on the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      drop_links();
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", out_data.status);
          errors++;
        end else begin
          compare_result(expected_results.pop_front(), out_data);
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(in_data));
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_lazy_delete_max_heap_with_links_core.sv =====
// Testbench top for the lazy-deletion heap: stimulus, clock, reset and verdict.
module tb_lazy_delete_max_heap_with_links_core;
  import ldmh_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_strobe;
  out_t out_data;
  int   pending;
  int   errors;
  int   cycles;
  int   idle_pct;
  in_t  pushed [$];

  lazy_delete_max_heap_with_links_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  heap_link_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t cmd(logic [2:0] op, logic signed [31:0] key, logic [15:0] ft,
                              logic [9:0] fp, logic [15:0] st, logic [9:0] sp);
    in_t c;
    c = '{op, key, ft, fp, st, sp};
    return c;
  endfunction

  // Start stays high across back-to-back commands; it drops only for an idle gap.
  task automatic send(in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= c;
    if (c.op == OP_PUSH) begin
      pushed.push_back(c);
      if (pushed.size() > 32) void'(pushed.pop_front());
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic in_t random_cmd();
    in_t c, ref_c;
    int sel;
    c.key = ($urandom_range(1) == 1) ? $signed($urandom_range(16)) - 8 : $signed($urandom);
    c.first_token = ($urandom_range(1) == 1) ? 16'($urandom_range(3)) : 16'($urandom);
    c.second_token = ($urandom_range(1) == 1) ? 16'($urandom_range(3)) : 16'($urandom);
    c.first_pos = ($urandom_range(1) == 1) ? 10'($urandom_range(15)) : 10'($urandom);
    c.second_pos = ($urandom_range(1) == 1) ? 10'($urandom_range(15)) : 10'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) c.op = OP_PUSH;
    else if (sel < 65) c.op = OP_POP;
    else if (sel < 80) c.op = OP_LEFT;
    else if (sel < 95) c.op = OP_RIGHT;
    else if (sel < 97) c.op = OP_CLEAR;
    else c.op = 3'($urandom_range(7, 5));
    // Most queries name a pair that was pushed recently.
    if (pushed.size() > 0 && $urandom_range(99) < 70) begin
      ref_c = pushed[$urandom_range(pushed.size() - 1)];
      if (c.op == OP_LEFT) begin
        c.first_token = ref_c.second_token;
        c.first_pos = ref_c.second_pos;
      end else if (c.op == OP_RIGHT) begin
        c.second_token = ref_c.first_token;
        c.second_pos = ref_c.first_pos;
      end
    end
    return c;
  endfunction

  initial begin
    cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, ties, duplicates, misses, empty pops, unused ops.
    send(cmd(OP_PUSH, 32'sh7fffffff, 16'hffff, 10'd1023, 16'hffff, 10'd1023));
    send(cmd(OP_PUSH, 32'sh80000000, 16'h0000, 10'd0, 16'h0000, 10'd0));
    send(cmd(OP_PUSH, 32'sd5, 16'h1234, 10'd1023, 16'h0001, 10'd7));
    send(cmd(OP_PUSH, 32'sd5, 16'h1234, 10'd8, 16'h0001, 10'd0));
    send(cmd(OP_PUSH, 32'sd5, 16'h0002, 10'd9, 16'h0003, 10'd10));
    send(cmd(OP_PUSH, 32'sd5, 16'h0004, 10'd11, 16'h0005, 10'd12));
    send(cmd(OP_LEFT, 32'sd0, 16'hffff, 10'd1023, 16'h0000, 10'd0));
    send(cmd(OP_LEFT, 32'sd0, 16'hfffe, 10'd1023, 16'h0000, 10'd0));
    send(cmd(OP_RIGHT, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));
    send(cmd(OP_RIGHT, 32'sd0, 16'h0000, 10'd0, 16'h0001, 10'd0));
    send(cmd(OP_RIGHT, 32'sd0, 16'h0000, 10'd0, 16'h0002, 10'd9));
    send(cmd(3'd5, 32'sh7fffffff, 16'hffff, 10'd1023, 16'hffff, 10'd1023));
    send(cmd(3'd6, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));
    send(cmd(3'd7, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));
    repeat (5) send(cmd(OP_POP, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));
    send(cmd(OP_LEFT, 32'sd0, 16'hffff, 10'd1023, 16'h0000, 10'd0));
    send(cmd(OP_PUSH, 32'sd1, 16'h0001, 10'd1, 16'h0001, 10'd1));
    send(cmd(OP_CLEAR, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));
    send(cmd(OP_POP, 32'sd0, 16'h0000, 10'd0, 16'h0000, 10'd0));

    // Random phases: no gaps, heavy gaps, light gaps, no gaps again.
    for (int n = 0; n < 520; n++) begin
      case (n / 130)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 8;
        default: idle_pct = 0;
      endcase
      send(random_cmd());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== lazy_delete_max_heap_with_links_core.f =====
+incdir+src
src/ldmh_pkg.sv
src/ldmh_ctrl.sv
src/ldmh_dp.sv
src/lazy_delete_max_heap_with_links_core.sv
dv/heap_link_checker.sv
dv/tb_lazy_delete_max_heap_with_links_core.sv
